### rtl/core/rconv_pkg.sv
// Shared types and constants of the raster 3x3 convolution block.
package rconv_pkg;

  localparam int PixelW  = 8;
  localparam int OutRowW = 12;
  localparam int OutColW = 10;
  localparam int ModeW   = 2;
  localparam int WidthW  = 11;
  localparam int HeightW = 13;
  localparam int AccW    = 13;

  localparam int DefMaxWidth  = 1024;
  localparam int DefMaxHeight = 4096;

  localparam int ResetWidth  = 1024;
  localparam int ResetHeight = 1024;

  localparam int ApbAddrW = 4;
  localparam int ApbDataW = 32;

  typedef enum logic [ModeW-1:0] {
    ModeSmooth  = 2'd0,
    ModeSharpen = 2'd1,
    ModeSobel   = 2'd2
  } filter_mode_e;

  typedef enum logic [1:0] {
    RegFilterMode  = 2'd0,
    RegImageWidth  = 2'd1,
    RegImageHeight = 2'd2
  } reg_index_e;

  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic [WidthW-1:0]  width;
    logic [HeightW-1:0] height;
    logic               restart;
  } cfg_t;

  typedef struct packed {
    logic i_zero;
    logic i_one;
    logic j_zero;
    logic j_one;
    logic row_end;
    logic last_row;
  } pos_flags_t;

endpackage

### rtl/core/raster_3x3_convolution.sv
// Top level of the streaming 3x3 convolution with zero padding.
//
//   port group     direction  request moved
//   pixel_*        in         one raster-order pixel
//   result_*       out        one filtered pixel with its row and column
//   psel/penable   in         one register write or read (APB)
//
// One pixel per clock is taken while the window stage is free and results
// drain one per clock. The window stage emits one result per clock: up to two
// for a pixel at a row end or in the last row, up to four for the last pixel
// of the frame, and holds the input for the extra cycles. The first result of
// a pixel passes the line memory read and input stage, the window stage and
// the output register. Reset clears control and the window only; the line
// memory is not cleared. A low result_ready_i holds the output register and
// backs up through the window and input stages to pixel_ready_o.
module raster_3x3_convolution #(
  parameter  int MaxWidth  = rconv_pkg::DefMaxWidth,
  parameter  int MaxHeight = rconv_pkg::DefMaxHeight,
  localparam int ColW      = $clog2(MaxWidth),
  localparam int RowW      = $clog2(MaxHeight)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rconv_pkg::ApbAddrW-1:0] paddr,
  input  logic [rconv_pkg::ApbDataW-1:0] pwdata,
  output logic [rconv_pkg::ApbDataW-1:0] prdata,
  output logic                           pready,
  input  logic                           pixel_valid_i,
  output logic                           pixel_ready_o,
  input  logic [rconv_pkg::PixelW-1:0]   pixel_in_i,
  output logic                           result_valid_o,
  input  logic                           result_ready_i,
  output logic [rconv_pkg::PixelW-1:0]   pixel_out_o,
  output logic [rconv_pkg::OutRowW-1:0]  out_row_o,
  output logic [rconv_pkg::OutColW-1:0]  out_col_o,
  output logic                           last_of_run_o,
  output logic                           frame_done_o
);

  rconv_pkg::cfg_t              cfg;
  logic                         a_valid;
  logic                         b_free;
  logic [rconv_pkg::PixelW-1:0] a_pix;
  logic [rconv_pkg::PixelW-1:0] a_above;
  logic [rconv_pkg::PixelW-1:0] a_above2;
  logic [RowW-1:0]              a_row;
  logic [ColW-1:0]              a_col;
  rconv_pkg::pos_flags_t        a_flags;

  rconv_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rconv_line_buf #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_line_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .pixel_in_i    (pixel_in_i),
    .a_valid_o     (a_valid),
    .b_free_i      (b_free),
    .pix_o         (a_pix),
    .above_o       (a_above),
    .above2_o      (a_above2),
    .row_o         (a_row),
    .col_o         (a_col),
    .flags_o       (a_flags)
  );

  rconv_window #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (cfg.mode),
    .a_valid_i      (a_valid),
    .b_free_o       (b_free),
    .pix_i          (a_pix),
    .above_i        (a_above),
    .above2_i       (a_above2),
    .row_i          (a_row),
    .col_i          (a_col),
    .flags_i        (a_flags),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .pixel_out_o    (pixel_out_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .last_of_run_o  (last_of_run_o),
    .frame_done_o   (frame_done_o)
  );

endmodule

### rtl/core/rconv_cfg.sv
// APB register file: filter mode, image width and image height.
module rconv_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rconv_pkg::ApbAddrW-1:0]   paddr,
  input  logic [rconv_pkg::ApbDataW-1:0]   pwdata,
  output logic [rconv_pkg::ApbDataW-1:0]   prdata,
  output logic                             pready,
  output rconv_pkg::cfg_t                  cfg_o
);

  logic [rconv_pkg::ModeW-1:0]   mode_q;
  logic [rconv_pkg::WidthW-1:0]  width_q;
  logic [rconv_pkg::HeightW-1:0] height_q;
  logic                          wr_en;
  logic                          restart;
  logic [1:0]                    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[rconv_pkg::ApbAddrW-1:2];

  always_comb begin
    restart = 1'b0;
    if (wr_en) begin
      case (reg_idx)
        rconv_pkg::RegImageWidth:  restart = 1'b1;
        rconv_pkg::RegImageHeight: restart = 1'b1;
        default:                   restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= rconv_pkg::ModeSmooth;
      width_q  <= rconv_pkg::WidthW'(rconv_pkg::ResetWidth);
      height_q <= rconv_pkg::HeightW'(rconv_pkg::ResetHeight);
    end else if (wr_en) begin
      case (reg_idx)
        rconv_pkg::RegFilterMode:  mode_q   <= pwdata[rconv_pkg::ModeW-1:0];
        rconv_pkg::RegImageWidth:  width_q  <= pwdata[rconv_pkg::WidthW-1:0];
        rconv_pkg::RegImageHeight: height_q <= pwdata[rconv_pkg::HeightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rconv_pkg::RegFilterMode:  prdata = rconv_pkg::ApbDataW'(mode_q);
      rconv_pkg::RegImageWidth:  prdata = rconv_pkg::ApbDataW'(width_q);
      rconv_pkg::RegImageHeight: prdata = rconv_pkg::ApbDataW'(height_q);
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o.mode    = mode_q;
  assign cfg_o.width   = width_q;
  assign cfg_o.height  = height_q;
  assign cfg_o.restart = restart;

endmodule

### rtl/core/rconv_line_buf.sv
// Raster position counters, two-row line memory with forwarding, input stage.
module rconv_line_buf #(
  parameter  int MaxWidth  = rconv_pkg::DefMaxWidth,
  parameter  int MaxHeight = rconv_pkg::DefMaxHeight,
  localparam int ColW      = $clog2(MaxWidth),
  localparam int RowW      = $clog2(MaxHeight)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rconv_pkg::cfg_t              cfg_i,
  input  logic                         pixel_valid_i,
  output logic                         pixel_ready_o,
  input  logic [rconv_pkg::PixelW-1:0] pixel_in_i,
  output logic                         a_valid_o,
  input  logic                         b_free_i,
  output logic [rconv_pkg::PixelW-1:0] pix_o,
  output logic [rconv_pkg::PixelW-1:0] above_o,
  output logic [rconv_pkg::PixelW-1:0] above2_o,
  output logic [RowW-1:0]              row_o,
  output logic [ColW-1:0]              col_o,
  output rconv_pkg::pos_flags_t        flags_o
);

  localparam int PixW   = rconv_pkg::PixelW;
  localparam int EntryW = 2 * PixW;
  localparam int WExtW  = (ColW + 1 > rconv_pkg::WidthW) ? ColW + 1 : rconv_pkg::WidthW;
  localparam int HExtW  = (RowW + 1 > rconv_pkg::HeightW) ? RowW + 1 : rconv_pkg::HeightW;

  logic [EntryW-1:0] line_mem [MaxWidth];
  logic [EntryW-1:0] rdata_q;
  logic [EntryW-1:0] fwd_data_q;
  logic              fwd_hit_q;
  logic [EntryW-1:0] entry;
  logic [EntryW-1:0] wr_data;

  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] last_col;
  logic [RowW-1:0] last_row;
  logic [WExtW-1:0] w_ext;
  logic [WExtW-1:0] w_eff;
  logic [HExtW-1:0] h_ext;
  logic [HExtW-1:0] h_eff;

  logic                   a_valid_q;
  logic [PixW-1:0]        a_pix_q;
  logic [RowW-1:0]        a_row_q;
  logic [ColW-1:0]        a_col_q;
  rconv_pkg::pos_flags_t  a_flags_q;
  rconv_pkg::pos_flags_t  flags;

  logic accept;
  logic a_adv;

  always_comb begin
    w_ext = WExtW'(cfg_i.width);
    if (w_ext == '0) begin
      w_eff = WExtW'(1);
    end else if (w_ext > WExtW'(MaxWidth)) begin
      w_eff = WExtW'(MaxWidth);
    end else begin
      w_eff = w_ext;
    end
    h_ext = HExtW'(cfg_i.height);
    if (h_ext == '0) begin
      h_eff = HExtW'(1);
    end else if (h_ext > HExtW'(MaxHeight)) begin
      h_eff = HExtW'(MaxHeight);
    end else begin
      h_eff = h_ext;
    end
    last_col = ColW'(w_eff - WExtW'(1));
    last_row = RowW'(h_eff - HExtW'(1));
  end

  always_comb begin
    flags.i_zero   = (row_q == '0);
    flags.i_one    = (row_q == RowW'(1));
    flags.j_zero   = (col_q == '0);
    flags.j_one    = (col_q == ColW'(1));
    flags.row_end  = (col_q >= last_col);
    flags.last_row = (row_q >= last_row);
  end

  assign pixel_ready_o = !a_valid_q || b_free_i;
  assign accept        = pixel_valid_i && pixel_ready_o;
  assign a_adv         = a_valid_q && b_free_i;

  assign entry   = fwd_hit_q ? fwd_data_q : rdata_q;
  assign wr_data = {a_pix_q, entry[EntryW-1:PixW]};

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      line_mem[a_col_q] <= wr_data;
    end
    if (accept) begin
      rdata_q <= line_mem[col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_data_q <= wr_data;
      a_pix_q    <= pixel_in_i;
      a_row_q    <= row_q;
      a_col_q    <= col_q;
      a_flags_q  <= flags;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
      a_valid_q <= 1'b0;
      col_q     <= '0;
      row_q     <= '0;
    end else begin
      if (accept) begin
        fwd_hit_q <= a_adv && (a_col_q == col_q);
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
      if (cfg_i.restart) begin
        col_q <= '0;
        row_q <= '0;
      end else if (accept) begin
        if (flags.row_end) begin
          col_q <= '0;
          row_q <= flags.last_row ? '0 : RowW'(row_q + RowW'(1));
        end else begin
          col_q <= ColW'(col_q + ColW'(1));
        end
      end
    end
  end

  assign a_valid_o = a_valid_q;
  assign pix_o     = a_pix_q;
  assign above_o   = entry[EntryW-1:PixW];
  assign above2_o  = entry[PixW-1:0];
  assign row_o     = a_row_q;
  assign col_o     = a_col_q;
  assign flags_o   = a_flags_q;

endmodule

### rtl/core/rconv_window.sv
// 3x3 window, result sequencing, kernel arithmetic and output register.
module rconv_window #(
  parameter  int MaxWidth  = rconv_pkg::DefMaxWidth,
  parameter  int MaxHeight = rconv_pkg::DefMaxHeight,
  localparam int ColW      = $clog2(MaxWidth),
  localparam int RowW      = $clog2(MaxHeight)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rconv_pkg::ModeW-1:0]   mode_i,
  input  logic                          a_valid_i,
  output logic                          b_free_o,
  input  logic [rconv_pkg::PixelW-1:0]  pix_i,
  input  logic [rconv_pkg::PixelW-1:0]  above_i,
  input  logic [rconv_pkg::PixelW-1:0]  above2_i,
  input  logic [RowW-1:0]               row_i,
  input  logic [ColW-1:0]               col_i,
  input  rconv_pkg::pos_flags_t         flags_i,
  output logic                          result_valid_o,
  input  logic                          result_ready_i,
  output logic [rconv_pkg::PixelW-1:0]  pixel_out_o,
  output logic [rconv_pkg::OutRowW-1:0] out_row_o,
  output logic [rconv_pkg::OutColW-1:0] out_col_o,
  output logic                          last_of_run_o,
  output logic                          frame_done_o
);

  localparam int PixW = rconv_pkg::PixelW;
  localparam int AccW = rconv_pkg::AccW;

  logic [PixW-1:0] win_q [3][3];

  logic [3:0]            pend_q;
  logic [RowW-1:0]       b_row_q;
  logic [ColW-1:0]       b_col_q;
  rconv_pkg::pos_flags_t b_flags_q;

  logic                         out_valid_q;
  logic [PixW-1:0]              out_pix_q;
  logic [rconv_pkg::OutRowW-1:0] out_row_q;
  logic [rconv_pkg::OutColW-1:0] out_col_q;
  logic                         out_last_q;
  logic                         out_done_q;

  logic [3:0]      new_mask;
  logic [3:0]      sel_oh;
  logic [3:0]      pend_next;
  logic            ro;
  logic            co;
  logic            top_mask;
  logic            left_mask;
  logic            out_free;
  logic            emit;
  logic            load;
  logic [RowW-1:0] res_row;
  logic [ColW-1:0] res_col;

  logic [PixW-1:0]        nb [3][3];
  logic signed [AccW-1:0] e  [3][3];
  logic signed [AccW-1:0] acc;
  logic [PixW-1:0]        res_pix;

  always_comb begin
    new_mask[0] = !flags_i.i_zero && !flags_i.j_zero;
    new_mask[1] = !flags_i.i_zero && flags_i.row_end;
    new_mask[2] = flags_i.last_row && !flags_i.j_zero;
    new_mask[3] = flags_i.last_row && flags_i.row_end;
  end

  always_comb begin
    sel_oh = 4'b0000;
    if (pend_q[0]) begin
      sel_oh = 4'b0001;
    end else if (pend_q[1]) begin
      sel_oh = 4'b0010;
    end else if (pend_q[2]) begin
      sel_oh = 4'b0100;
    end else if (pend_q[3]) begin
      sel_oh = 4'b1000;
    end
  end

  assign pend_next = pend_q & ~sel_oh;
  assign ro        = sel_oh[2] | sel_oh[3];
  assign co        = sel_oh[1] | sel_oh[3];
  assign top_mask  = ro ? b_flags_q.i_zero : b_flags_q.i_one;
  assign left_mask = co ? b_flags_q.j_zero : b_flags_q.j_one;
  assign res_row   = ro ? b_row_q : RowW'(b_row_q - RowW'(1));
  assign res_col   = co ? b_col_q : ColW'(b_col_q - ColW'(1));

  assign out_free = !out_valid_q || result_ready_i;
  assign emit     = (pend_q != 4'b0000) && out_free;
  assign b_free_o = (pend_q == 4'b0000) || (emit && (pend_next == 4'b0000));
  assign load     = a_valid_i && b_free_o;

  always_comb begin
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        nb[dr][dc] = '0;
        if ((!ro || dr < 2) && (!co || dc < 2)) begin
          nb[dr][dc] = win_q[dr + int'(ro)][dc + int'(co)];
        end
        if ((dr == 0 && top_mask) || (dc == 0 && left_mask)) begin
          nb[dr][dc] = '0;
        end
        e[dr][dc] = $signed(AccW'(nb[dr][dc]));
      end
    end
  end

  always_comb begin
    case (mode_i)
      rconv_pkg::ModeSharpen: begin
        acc = (e[1][1] <<< 3) + e[1][1]
            - ((e[0][1] + e[1][0] + e[1][2] + e[2][1]) <<< 1);
      end
      rconv_pkg::ModeSobel: begin
        acc = (e[2][0] + (e[2][1] <<< 1) + e[2][2])
            - (e[0][0] + (e[0][1] <<< 1) + e[0][2]);
      end
      default: begin
        acc = (e[0][0] + e[0][1] + e[1][0] + (e[1][1] <<< 1) + e[1][2]
            + e[2][1] + e[2][2]) >>> 3;
      end
    endcase
    if (acc < 0) begin
      res_pix = '0;
    end else if (acc > AccW'(255)) begin
      res_pix = '1;
    end else begin
      res_pix = acc[PixW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (load) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= above2_i;
      win_q[1][2] <= above_i;
      win_q[2][2] <= pix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      b_row_q   <= row_i;
      b_col_q   <= col_i;
      b_flags_q <= flags_i;
    end
    if (emit) begin
      out_pix_q  <= res_pix;
      out_row_q  <= rconv_pkg::OutRowW'(res_row);
      out_col_q  <= rconv_pkg::OutColW'(res_col);
      out_last_q <= (pend_next == 4'b0000);
      out_done_q <= sel_oh[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 4'b0000;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        pend_q <= new_mask;
      end else if (emit) begin
        pend_q <= pend_next;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (result_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign result_valid_o = out_valid_q;
  assign pixel_out_o    = out_pix_q;
  assign out_row_o      = out_row_q;
  assign out_col_o      = out_col_q;
  assign last_of_run_o  = out_last_q;
  assign frame_done_o   = out_done_q;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the raster 3x3 convolution block.
module tb;

  localparam int PixelW       = rconv_pkg::PixelW;
  localparam int OutRowW      = rconv_pkg::OutRowW;
  localparam int OutColW      = rconv_pkg::OutColW;
  localparam int ModeW        = rconv_pkg::ModeW;
  localparam int WidthW       = rconv_pkg::WidthW;
  localparam int HeightW      = rconv_pkg::HeightW;
  localparam int ApbAddrW     = rconv_pkg::ApbAddrW;
  localparam int ApbDataW     = rconv_pkg::ApbDataW;
  localparam int MaxCols      = rconv_pkg::DefMaxWidth;
  localparam int MaxRows      = rconv_pkg::DefMaxHeight;
  localparam int NoTyped      = -1;
  localparam int RandomPixels = 160;
  localparam int TailPixels   = 24;
  localparam int PlanLen      = 35;
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  typedef enum bit {RowPixel, RowReg} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    rconv_pkg::reg_index_e idx;
    logic [31:0]           value;
    int                    typed;
  } stim_row_t;

  typedef struct packed {
    logic [PixelW-1:0]  pixel;
    logic [OutRowW-1:0] row;
    logic [OutColW-1:0] col;
    logic               last_of_run;
    logic               frame_done;
  } filtered_pixel_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                pixel_valid_i;
  logic                pixel_ready_o;
  logic [PixelW-1:0]   pixel_in_i;
  logic                result_valid_o;
  logic                result_ready_i;
  logic [PixelW-1:0]   pixel_out_o;
  logic [OutRowW-1:0]  out_row_o;
  logic [OutColW-1:0]  out_col_o;
  logic                last_of_run_o;
  logic                frame_done_o;

  int typed_pixel_out;
  bit steady;
  int errors;

  logic [ModeW-1:0]   mode_q;
  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [PixelW-1:0]  prev_row [MaxCols];
  logic [PixelW-1:0]  prev_row2 [MaxCols];
  logic [PixelW-1:0]  win [3][3];
  int                 next_row;
  int                 next_col;
  filtered_pixel_t    filtered_q [$];

  stim_row_t plan [PlanLen] = '{
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd255,                    NoTyped},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd0,                      NoTyped},
    '{RowReg,   rconv_pkg::RegImageWidth,  32'd0,                      NoTyped},
    '{RowReg,   rconv_pkg::RegImageHeight, 32'd0,                      NoTyped},
    '{RowReg,   rconv_pkg::RegFilterMode,  32'(rconv_pkg::ModeSmooth),  NoTyped},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd255,                    63},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd0,                      0},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd7,                      1},
    '{RowReg,   rconv_pkg::RegFilterMode,  32'(rconv_pkg::ModeSharpen), NoTyped},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd255,                    255},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd28,                     252},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd29,                     255},
    '{RowReg,   rconv_pkg::RegFilterMode,  32'(rconv_pkg::ModeSobel),   NoTyped},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd255,                    0},
    '{RowReg,   rconv_pkg::RegFilterMode,  32'(ModeUnused),            NoTyped},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd200,                    50},
    '{RowReg,   rconv_pkg::RegFilterMode,  32'(rconv_pkg::ModeSobel),   NoTyped},
    '{RowReg,   rconv_pkg::RegImageWidth,  32'd3,                      NoTyped},
    '{RowReg,   rconv_pkg::RegImageHeight, 32'd3,                      NoTyped},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd0,                      NoTyped},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd255,                    NoTyped},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd128,                    NoTyped},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd1,                      NoTyped},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd254,                    NoTyped},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd127,                    NoTyped},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd255,                    NoTyped},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd0,                      NoTyped},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd64,                     NoTyped},
    '{RowReg,   rconv_pkg::RegFilterMode,  32'(rconv_pkg::ModeSharpen), NoTyped},
    '{RowReg,   rconv_pkg::RegImageWidth,  32'd2,                      NoTyped},
    '{RowReg,   rconv_pkg::RegImageHeight, 32'd2,                      NoTyped},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd255,                    NoTyped},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd0,                      NoTyped},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd3,                      NoTyped},
    '{RowPixel, rconv_pkg::RegFilterMode,  32'd255,                    NoTyped}
  };

  raster_3x3_convolution i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .pixel_valid_i  (pixel_valid_i),
    .pixel_ready_o  (pixel_ready_o),
    .pixel_in_i     (pixel_in_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .pixel_out_o    (pixel_out_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .last_of_run_o  (last_of_run_o),
    .frame_done_o   (frame_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int active_width();
    if (width_q == 0) return 1;
    if (width_q > MaxCols) return MaxCols;
    return int'(width_q);
  endfunction

  function automatic int active_height();
    if (height_q == 0) return 1;
    if (height_q > MaxRows) return MaxRows;
    return int'(height_q);
  endfunction

  function automatic int kernel_weight(int dr, int dc);
    case (mode_q)
      rconv_pkg::ModeSharpen:
        return (dr == 0 && dc == 0) ? 9 : ((dr == 0 || dc == 0) ? -2 : 0);
      rconv_pkg::ModeSobel:
        return (dc == 0) ? 2 * dr : dr;
      default:
        return (dr == 0 && dc == 0) ? 2 : ((dr != 0 && dr == -dc) ? 0 : 1);
    endcase
  endfunction

  function automatic logic [PixelW-1:0] filter_at_pos(int rc, int cc);
    int acc, nr, nc, wr, wc, w, h, dr, dc;
    w = active_width();
    h = active_height();
    acc = 0;
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        nr = rc + dr;
        nc = cc + dc;
        wr = nr - (next_row - 2);
        wc = nc - (next_col - 2);
        if (nr >= 0 && nr < h && nc >= 0 && nc < w && wr >= 0 && wr <= 2 && wc >= 0 && wc <= 2)
          acc += kernel_weight(dr, dc) * int'(win[wr][wc]);
      end
    end
    if (mode_q != rconv_pkg::ModeSharpen && mode_q != rconv_pkg::ModeSobel) acc = acc / 8;
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    return acc[PixelW-1:0];
  endfunction

  function automatic void queue_filtered(int rc, int cc, bit done);
    filtered_pixel_t res;
    res.pixel       = filter_at_pos(rc, cc);
    res.row         = rc[OutRowW-1:0];
    res.col         = cc[OutColW-1:0];
    res.last_of_run = 1'b0;
    res.frame_done  = done;
    filtered_q.insert(filtered_q.size(), res);
  endfunction

  function automatic void convolve_pixel(logic [PixelW-1:0] value, int typed);
    int w, h, idx, n, r;
    bit row_end, last_row;
    logic [PixelW-1:0] above, above2;
    filtered_pixel_t res;
    w = active_width();
    h = active_height();
    idx = next_col % MaxCols;
    above = prev_row[idx];
    above2 = prev_row2[idx];
    row_end = next_col >= w - 1;
    last_row = next_row >= h - 1;
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = above2;
    win[1][2] = above;
    win[2][2] = value;
    prev_row2[idx] = above;
    prev_row[idx] = value;
    n = 0;
    if (next_row >= 1 && next_col >= 1) begin
      queue_filtered(next_row - 1, next_col - 1, 1'b0);
      n++;
    end
    if (next_row >= 1 && row_end) begin
      queue_filtered(next_row - 1, next_col, 1'b0);
      n++;
    end
    if (last_row && next_col >= 1) begin
      queue_filtered(next_row, next_col - 1, 1'b0);
      n++;
    end
    if (last_row && row_end) begin
      queue_filtered(next_row, next_col, 1'b1);
      n++;
    end
    if (n > 0) begin
      res = filtered_q.pop_back();
      res.last_of_run = 1'b1;
      if (typed != NoTyped) res.pixel = typed[PixelW-1:0];
      filtered_q.insert(filtered_q.size(), res);
    end
    if (row_end) begin
      next_col = 0;
      next_row = last_row ? 0 : next_row + 1;
    end else begin
      next_col++;
    end
  endfunction

  function automatic void apply_register(rconv_pkg::reg_index_e idx,
                                         logic [ApbDataW-1:0] value);
    case (idx)
      rconv_pkg::RegFilterMode: mode_q = value[ModeW-1:0];
      rconv_pkg::RegImageWidth: begin
        width_q = value[WidthW-1:0];
        next_row = 0;
        next_col = 0;
      end
      rconv_pkg::RegImageHeight: begin
        height_q = value[HeightW-1:0];
        next_row = 0;
        next_col = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  function automatic void check_filtered();
    filtered_pixel_t want;
    if (filtered_q.size() == 0) begin
      $display("%0t: result expected none, got pixel %0d at row %0d col %0d",
               $time, pixel_out_o, out_row_o, out_col_o);
      errors++;
    end else begin
      want = filtered_q.pop_front();
      check_field("pixel_out", 32'(want.pixel), 32'(pixel_out_o));
      check_field("out_row", 32'(want.row), 32'(out_row_o));
      check_field("out_col", 32'(want.col), 32'(out_col_o));
      check_field("last_of_run", 32'(want.last_of_run), 32'(last_of_run_o));
      check_field("frame_done", 32'(want.frame_done), 32'(frame_done_o));
    end
  endfunction

  function automatic logic [PixelW-1:0] rand_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PixelW'($urandom_range(255));
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pixel_valid_i && pixel_ready_o) convolve_pixel(pixel_in_i, typed_pixel_out);
      if (result_valid_o && result_ready_i) check_filtered();
    end
  end

  always @(posedge clk_i) begin
    result_ready_i <= steady || ($urandom_range(99) >= 33);
  end

  task automatic push_pixel(logic [PixelW-1:0] value, int typed);
    while (!steady && $urandom_range(99) < 33) begin
      pixel_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    pixel_valid_i <= 1'b1;
    pixel_in_i <= value;
    typed_pixel_out <= typed;
    do @(posedge clk_i); while (!pixel_ready_o);
  endtask

  // hold until every request has left the pipeline
  task automatic drain_results();
    pixel_valid_i <= 1'b0;
    @(posedge clk_i);
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic read_reg(rconv_pkg::reg_index_e idx);
    logic [ApbDataW-1:0] want;
    case (idx)
      rconv_pkg::RegFilterMode: want = ApbDataW'(mode_q);
      rconv_pkg::RegImageWidth: want = ApbDataW'(width_q);
      default:                  want = ApbDataW'(height_q);
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    check_field("prdata", want, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(rconv_pkg::reg_index_e idx, logic [ApbDataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    apply_register(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    read_reg(idx);
  endtask

  initial begin
    int w, h, total, mode_at, random_sent, c;
    errors = 0;
    steady = 1'b0;
    random_sent = 0;
    typed_pixel_out = NoTyped;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pixel_valid_i = 1'b0;
    pixel_in_i = '0;
    result_ready_i = 1'b0;
    mode_q = rconv_pkg::ModeSmooth;
    width_q = WidthW'(rconv_pkg::ResetWidth);
    height_q = HeightW'(rconv_pkg::ResetHeight);
    next_row = 0;
    next_col = 0;
    for (c = 0; c < MaxCols; c++) begin
      prev_row[c] = '0;
      prev_row2[c] = '0;
    end
    for (c = 0; c < 9; c++) win[c / 3][c % 3] = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    read_reg(rconv_pkg::RegFilterMode);
    read_reg(rconv_pkg::RegImageWidth);
    read_reg(rconv_pkg::RegImageHeight);

    foreach (plan[r]) begin
      if (plan[r].kind == RowReg) begin
        drain_results();
        write_reg(plan[r].idx, plan[r].value);
      end else begin
        push_pixel(plan[r].value[PixelW-1:0], plan[r].typed);
      end
    end

    while (random_sent < RandomPixels) begin
      steady = ($urandom_range(5) == 0);
      drain_results();
      write_reg(rconv_pkg::RegFilterMode, ApbDataW'($urandom_range(3)));
      w = ($urandom_range(4) == 0) ? $urandom_range(40, 9) : $urandom_range(6, 1);
      h = $urandom_range(5, 1);
      write_reg(rconv_pkg::RegImageWidth, ApbDataW'(w));
      write_reg(rconv_pkg::RegImageHeight, ApbDataW'(h));
      total = w * h * $urandom_range(2, 1);
      // drop the tail of the frame now and then
      if (total > 1 && $urandom_range(4) == 0) total = $urandom_range(total - 1, 1);
      if (total > RandomPixels - random_sent) total = RandomPixels - random_sent;
      mode_at = ($urandom_range(3) == 0) ? $urandom_range(total - 1) : 0;
      for (int k = 0; k < total; k++) begin
        if (k == mode_at && k > 0) begin
          drain_results();
          write_reg(rconv_pkg::RegFilterMode, ApbDataW'($urandom_range(3)));
        end
        push_pixel(rand_pixel(), NoTyped);
      end
      random_sent += total;
    end

    steady = 1'b1;
    drain_results();
    write_reg(rconv_pkg::RegFilterMode, ApbDataW'(rconv_pkg::ModeSharpen));
    write_reg(rconv_pkg::RegImageWidth, '1);
    write_reg(rconv_pkg::RegImageHeight, ApbDataW'(1));
    repeat (TailPixels) push_pixel(rand_pixel(), NoTyped);
    steady = 1'b0;

    drain_results();
    write_reg(rconv_pkg::RegFilterMode, ApbDataW'($urandom_range(3)));
    write_reg(rconv_pkg::RegImageWidth, ApbDataW'(1));
    write_reg(rconv_pkg::RegImageHeight, '1);
    repeat (TailPixels) push_pixel(rand_pixel(), NoTyped);

    drain_results();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
